// ===== src/tarq_pkg.sv =====
// Shared types and constants for the tilt auto-rotation qualifier.
// No dependencies; used by every module of the block under src.
package tarq_pkg;

	// Result status codes
	typedef enum logic [3:0] {
		ST_CHANGED   = 4'd0,
		ST_DISABLED  = 4'd1,
		ST_TOO_SOON  = 4'd2,
		ST_PAUSED    = 4'd3,
		ST_READ_FAIL = 4'd4,
		ST_UNSETTLED = 4'd5,
		ST_SAME      = 4'd6,
		ST_LOCK_BUSY = 4'd7,
		ST_PAUSE_OK  = 4'd8
	} status_t;

	// Item function codes
	typedef enum logic {
		FUNC_POLL  = 1'b0,
		FUNC_PAUSE = 1'b1
	} func_t;

	// Register indexes on the APB port (byte address 4*index)
	typedef enum logic [1:0] {
		REG_ENABLE    = 2'd0,
		REG_DEAD_ZONE = 2'd1,
		REG_INTERVAL  = 2'd2,
		REG_SETTLE    = 2'd3
	} reg_idx_t;

	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;

	// Magnitude of a 16-bit signed sample, up to 32768, is held in 17 bits
	localparam int unsigned MagW  = 17;
	// 115 * 32768 fits in 24 bits
	localparam int unsigned ProdW = 24;

	// Dominance ratio 115/100, kept as integer weights
	localparam logic [6:0] DomNum = 7'd115;
	localparam logic [6:0] DomDen = 7'd100;

	// Rotation codes: 0, 90, 180, 270 degrees
	typedef logic [1:0] rot_t;
	localparam rot_t ROT_0   = 2'd0;
	localparam rot_t ROT_90  = 2'd1;
	localparam rot_t ROT_180 = 2'd2;
	localparam rot_t ROT_270 = 2'd3;

	// Register reset values
	localparam logic        EnableRst   = 1'b1;
	localparam logic [14:0] DeadZoneRst = 15'd350;
	localparam logic [15:0] IntervalRst = 16'd400;
	localparam logic [3:0]  SettleRst   = 4'd3;

	// Configuration bundle handed from the register file to the datapath
	typedef struct packed {
		logic        enable;
		logic [14:0] dead_zone_mg;
		logic [15:0] poll_interval_ms;
		logic [3:0]  settle_count;
	} cfg_t;

endpackage

// ===== src/tarq_cfg_regs.sv =====
// APB-style configuration register file for the tilt qualifier.
// Depends on tarq_pkg for register indexes, reset values and cfg_t.
module tarq_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tarq_pkg::AddrW-1:0]  paddr,
	input  logic [tarq_pkg::DataW-1:0]  pwdata,
	output logic [tarq_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output tarq_pkg::cfg_t              cfg
);

	tarq_pkg::cfg_t   cfg_q;
	tarq_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = tarq_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= tarq_pkg::EnableRst;
			cfg_q.dead_zone_mg     <= tarq_pkg::DeadZoneRst;
			cfg_q.poll_interval_ms <= tarq_pkg::IntervalRst;
			cfg_q.settle_count     <= tarq_pkg::SettleRst;
		end else if (wr_en) begin
			case (idx)
				tarq_pkg::REG_ENABLE:    cfg_q.enable           <= pwdata[0];
				tarq_pkg::REG_DEAD_ZONE: cfg_q.dead_zone_mg     <= pwdata[14:0];
				tarq_pkg::REG_INTERVAL:  cfg_q.poll_interval_ms <= pwdata[15:0];
				tarq_pkg::REG_SETTLE:    cfg_q.settle_count     <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			tarq_pkg::REG_ENABLE:    prdata = {31'd0, cfg_q.enable};
			tarq_pkg::REG_DEAD_ZONE: prdata = {17'd0, cfg_q.dead_zone_mg};
			tarq_pkg::REG_INTERVAL:  prdata = {16'd0, cfg_q.poll_interval_ms};
			tarq_pkg::REG_SETTLE:    prdata = {28'd0, cfg_q.settle_count};
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== src/tarq_classify.sv =====
// Rotation classifier: dead zone and dominant-axis sign test on one sample.
// Depends on tarq_pkg for widths, dominance weights and rotation codes.
module tarq_classify (
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic [14:0]        dead_zone_mg,
	input  tarq_pkg::rot_t     shown,
	output tarq_pkg::rot_t     want
);

	logic [tarq_pkg::MagW-1:0]  mag_x, mag_y, dz;
	logic [tarq_pkg::ProdW-1:0] x_den, y_den, x_num, y_num;
	logic                       x_pos, y_pos, in_dead;

	// Magnitudes (17 bits so that -32768 is exact)
	always_comb begin
		mag_x = accel_x[15] ? tarq_pkg::MagW'(17'd0 - {accel_x[15], accel_x})
		                    : tarq_pkg::MagW'({1'b0, accel_x});
		mag_y = accel_y[15] ? tarq_pkg::MagW'(17'd0 - {accel_y[15], accel_y})
		                    : tarq_pkg::MagW'({1'b0, accel_y});
	end

	assign x_pos = !accel_x[15] && (accel_x != 16'sd0);
	assign y_pos = !accel_y[15] && (accel_y != 16'sd0);

	assign dz      = {2'b00, dead_zone_mg};
	assign in_dead = (mag_x < dz) && (mag_y < dz);

	// Constant-weight products for the 115/100 dominance test
	assign x_den = tarq_pkg::ProdW'(mag_x) * tarq_pkg::ProdW'(tarq_pkg::DomDen);
	assign y_den = tarq_pkg::ProdW'(mag_y) * tarq_pkg::ProdW'(tarq_pkg::DomDen);
	assign x_num = tarq_pkg::ProdW'(mag_x) * tarq_pkg::ProdW'(tarq_pkg::DomNum);
	assign y_num = tarq_pkg::ProdW'(mag_y) * tarq_pkg::ProdW'(tarq_pkg::DomNum);

	// Pick the rotation, holding the shown one in the dead zone or when nothing dominates
	always_comb begin
		if (in_dead) begin
			want = shown;
		end else if (x_den > y_num) begin
			want = x_pos ? tarq_pkg::ROT_90 : tarq_pkg::ROT_270;
		end else if (y_den > x_num) begin
			want = y_pos ? tarq_pkg::ROT_0 : tarq_pkg::ROT_180;
		end else begin
			want = shown;
		end
	end

endmodule

// ===== src/tilt_auto_rotation_qualifier.sv =====
// Top level of the tilt auto-rotation qualifier: input register, decision
// logic with qualifier state, result register. Uses tarq_pkg, tarq_cfg_regs
// and tarq_classify.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid / in_stall     | func now_ms accel_x accel_y read_ok
//           |                         | lock_ok pause_ms
//   out     | out_valid / out_stall   | rotation changed status
//   cfg     | psel penable pwrite     | paddr pwdata prdata (pready tied high)
//
// One item per cycle sustained while out_stall is low; an item passes through the
// input register, then the decision logic into the result register.
// The qualifier state updates when an item moves into the result register, so
// the next item sees it in the following cycle.
// Reset clears the valid flags and returns state and registers to defaults.
// A stalled result holds; the input register still takes one more transfer,
// then in_stall rises until the result is taken.
module tilt_auto_rotation_qualifier (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [31:0]                 now_ms,
	input  logic signed [15:0]          accel_x,
	input  logic signed [15:0]          accel_y,
	input  logic                        read_ok,
	input  logic                        lock_ok,
	input  logic [31:0]                 pause_ms,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  rotation,
	output logic                        changed,
	output logic [3:0]                  status,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tarq_pkg::AddrW-1:0]  paddr,
	input  logic [tarq_pkg::DataW-1:0]  pwdata,
	output logic [tarq_pkg::DataW-1:0]  prdata,
	output logic                        pready
);

	tarq_pkg::cfg_t cfg;

	// input register
	logic               valid_s1;
	logic               func_s1;
	logic [31:0]        now_s1;
	logic signed [15:0] ax_s1, ay_s1;
	logic               read_ok_s1, lock_ok_s1;
	logic [31:0]        pause_ms_s1;

	// qualifier state
	logic [31:0]    last_poll_q, pause_until_q;
	tarq_pkg::rot_t cand_q, shown_q;
	logic [3:0]     agree_q;

	// result register
	logic             out_valid_q;
	tarq_pkg::rot_t   rotation_q;
	logic             changed_q;
	tarq_pkg::status_t status_q;

	// decision outputs
	logic [31:0]       last_poll_d, pause_until_d;
	tarq_pkg::rot_t    cand_d, shown_d, want;
	logic [3:0]        agree_d, agree_inc;
	tarq_pkg::status_t status_d;
	logic [31:0]       since_last;

	logic out_free, advance, in_xfer;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	tarq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tarq_classify u_classify (
		.accel_x      (ax_s1),
		.accel_y      (ay_s1),
		.dead_zone_mg (cfg.dead_zone_mg),
		.shown        (shown_q),
		.want         (want)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1     <= func;
			now_s1      <= now_ms;
			ax_s1       <= accel_x;
			ay_s1       <= accel_y;
			read_ok_s1  <= read_ok;
			lock_ok_s1  <= lock_ok;
			pause_ms_s1 <= pause_ms;
		end
	end

	assign since_last = now_s1 - last_poll_q;
	assign agree_inc  = (agree_q < cfg.settle_count) ? agree_q + 4'd1 : agree_q;

	// Decision chain for the item in the input register
	always_comb begin
		last_poll_d   = last_poll_q;
		pause_until_d = pause_until_q;
		cand_d        = cand_q;
		agree_d       = agree_q;
		shown_d       = shown_q;
		status_d      = tarq_pkg::ST_SAME;
		if (tarq_pkg::func_t'(func_s1) == tarq_pkg::FUNC_PAUSE) begin
			pause_until_d = now_s1 + pause_ms_s1;
			agree_d       = 4'd0;
			status_d      = tarq_pkg::ST_PAUSE_OK;
		end else if (!cfg.enable) begin
			status_d = tarq_pkg::ST_DISABLED;
		end else if (since_last < {16'd0, cfg.poll_interval_ms}) begin
			status_d = tarq_pkg::ST_TOO_SOON;
		end else begin
			last_poll_d = now_s1;
			if (now_s1 < pause_until_q) begin
				status_d = tarq_pkg::ST_PAUSED;
			end else if (!read_ok_s1) begin
				status_d = tarq_pkg::ST_READ_FAIL;
			end else if (want != cand_q) begin
				// new candidate restarts the agreement count
				cand_d   = want;
				agree_d  = 4'd0;
				status_d = tarq_pkg::ST_UNSETTLED;
			end else begin
				agree_d = agree_inc;
				if (agree_inc < cfg.settle_count) begin
					status_d = tarq_pkg::ST_UNSETTLED;
				end else if (want == shown_q) begin
					status_d = tarq_pkg::ST_SAME;
				end else if (!lock_ok_s1) begin
					status_d = tarq_pkg::ST_LOCK_BUSY;
				end else begin
					shown_d  = want;
					status_d = tarq_pkg::ST_CHANGED;
				end
			end
		end
	end

	// Qualifier state, updated as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_poll_q   <= '0;
			pause_until_q <= '0;
			cand_q        <= tarq_pkg::ROT_90;
			agree_q       <= '0;
			shown_q       <= tarq_pkg::ROT_90;
		end else if (advance) begin
			last_poll_q   <= last_poll_d;
			pause_until_q <= pause_until_d;
			cand_q        <= cand_d;
			agree_q       <= agree_d;
			shown_q       <= shown_d;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rotation_q <= shown_d;
			changed_q  <= (status_d == tarq_pkg::ST_CHANGED);
			status_q   <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign rotation  = rotation_q;
	assign changed   = changed_q;
	assign status    = status_q;

	// The shown rotation moves only together with a "changed" result
	a_shown_moves_with_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(shown_q) |-> out_valid_q && status_q == tarq_pkg::ST_CHANGED)
		else $error("shown rotation changed without a changed result");

	// The pause window end moves only through a pause item
	a_pause_moves_with_pause: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pause_until_q) |-> out_valid_q && status_q == tarq_pkg::ST_PAUSE_OK)
		else $error("pause window moved without a pause item");

	// The last poll time is not taken from pause, disabled or too-soon items
	a_last_poll_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_poll_q) |-> out_valid_q
			&& status_q != tarq_pkg::ST_PAUSE_OK
			&& status_q != tarq_pkg::ST_DISABLED
			&& status_q != tarq_pkg::ST_TOO_SOON)
		else $error("last poll time updated by a rejected item");

	// A registered result reports the rotation the state now holds
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> rotation_q == shown_q)
		else $error("result rotation differs from shown rotation");

	// changed flag agrees with the status code
	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> changed_q == (status_q == tarq_pkg::ST_CHANGED))
		else $error("changed flag and status disagree");

endmodule
